### rtl/assert_macros.svh
// Assertion helpers for the cluster chain walker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("invariant violated");
// Antecedent at one edge implies the consequent at the next edge.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_ALWAYS(label, clk, rstn, prop)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### rtl/fccw_pkg.sv
package fccw_pkg;

    localparam int CL_W    = 12;
    localparam int IDX_W   = 13;
    localparam int BYTE_W  = 8;
    localparam int OFF_W   = 32;
    localparam int CFG_W   = 16;
    localparam int CFGI_W  = 3;
    localparam int CBYTE_W = 21;   // sectors_per_cluster * bytes_per_sector

    localparam logic [CL_W-1:0] ENTRY_LAST = 12'hFF8;
    localparam logic [CL_W-1:0] ENTRY_BAD  = 12'hFF7;
    localparam int DIR_ENTRY_SHIFT = 5;   // 32 bytes per root entry

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_START   = 2'd1,
        CMD_ADVANCE = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CONTINUE = 3'd0,
        ST_LAST     = 3'd1,
        ST_BAD      = 3'd2,
        ST_NO_CHAIN = 3'd3,
        ST_INVALID  = 3'd4
    } status_t;

    localparam logic [CFGI_W-1:0] CFG_BYTES_PER_SECTOR    = 3'd0;
    localparam logic [CFGI_W-1:0] CFG_SECTORS_PER_CLUSTER = 3'd1;
    localparam logic [CFGI_W-1:0] CFG_RESERVED_SECTORS    = 3'd2;
    localparam logic [CFGI_W-1:0] CFG_TABLE_COPIES        = 3'd3;
    localparam logic [CFGI_W-1:0] CFG_ROOT_ENTRIES        = 3'd4;
    localparam logic [CFGI_W-1:0] CFG_TABLE_SECTORS       = 3'd5;

    typedef struct packed {
        logic [OFF_W-1:0]   base;           // byte offset of cluster 2
        logic [CBYTE_W-1:0] cluster_bytes;  // bytes in one cluster
        logic               busy;           // recompute in progress
    } geo_t;

endpackage

### rtl/fat12_cluster_chain_walker.sv
// FAT12 cluster chain walker. Load items (cmd 0) write one byte of the
// first allocation table into on-chip memory and give no result. Start
// (cmd 1) and advance (cmd 2) items each give one result: the cluster, its
// byte offset in the volume image, the packed 12-bit entry read for it and
// a status (continue, last, bad, no chain, invalid cluster). In a lookup,
// the accept cycle issues both table byte reads on the memory's two read
// ports, and the next cycle decodes the entry and loads the output
// register; the next item is taken the cycle after. The decode cycle waits
// while the output register still holds a result that the receiver has not
// taken. The volume-geometry registers feed a data-area base that is
// recomputed by a bit-serial divider and two multiply steps after reset and
// after every configuration write; no transaction is accepted until it
// finishes. Unused command 3 is accepted and dropped.
`include "assert_macros.svh"

module fat12_cluster_chain_walker
    import fccw_pkg::*;
#(
    parameter int TABLE_BYTES = 8192
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              cfg_wr_en,
    input  logic [CFGI_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_wr_data,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_cmd,
    input  logic [IDX_W-1:0]  s_table_index,
    input  logic [BYTE_W-1:0] s_table_byte,
    input  logic [CL_W-1:0]   s_start_cluster,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [CL_W-1:0]   m_cluster_number,
    output logic [OFF_W-1:0]  m_data_offset,
    output logic [CL_W-1:0]   m_next_entry,
    output logic [2:0]        m_status
);

    localparam int AW   = $clog2(TABLE_BYTES);
    localparam int CMPW = 17;   // holds TABLE_BYTES at its maximum

    typedef enum logic [1:0] {
        T_IDLE = 2'b01,
        T_LOOK = 2'b10
    } tstate_t;

    geo_t geo;

    fccw_geometry u_geometry (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .geo        (geo)
    );

    tstate_t state_reg, state_next;

    logic            chain_active_reg, chain_active_next;
    logic [CL_W-1:0] pending_reg, pending_next;

    // lookup in flight
    logic [CL_W-1:0]  cl_reg;
    logic             idle_adv_reg;
    logic             rng0_reg, rng1_reg;
    logic [OFF_W-1:0] prod_reg;

    // output register
    logic             m_valid_reg, m_valid_next;
    logic [CL_W-1:0]  m_cl_reg;
    logic [OFF_W-1:0] m_off_reg;
    logic [CL_W-1:0]  m_entry_reg;
    status_t          m_status_reg;

    logic accept;
    logic is_load, is_lookup;
    logic out_free;

    logic [CL_W-1:0]  cl_sel;
    logic [IDX_W-1:0] pos0, pos1;
    logic [CL_W-1:0]  cl_minus2;

    logic [BYTE_W-1:0] rd_a, rd_b;
    logic [15:0]       pair;
    logic [CL_W-1:0]   entry;

    logic [CL_W-1:0]  res_cl;
    logic [OFF_W-1:0] res_off;
    logic [CL_W-1:0]  res_entry;
    status_t          res_status;
    logic             res_write;

    assign s_ready   = (state_reg == T_IDLE) && !geo.busy && !cfg_wr_en;
    assign accept    = s_valid && s_ready;
    assign is_load   = (s_cmd == CMD_LOAD);
    assign is_lookup = (s_cmd == CMD_START) || (s_cmd == CMD_ADVANCE);
    assign out_free  = !m_valid_reg || m_ready;

    // table position of the entry: cluster * 1.5
    assign cl_sel    = (s_cmd == CMD_START) ? s_start_cluster : pending_reg;
    assign pos0      = IDX_W'(cl_sel) + IDX_W'(cl_sel >> 1);
    assign pos1      = pos0 + IDX_W'(1);
    assign cl_minus2 = cl_sel - CL_W'(2);

    fccw_table_mem #(
        .DEPTH(TABLE_BYTES),
        .AW   (AW)
    ) u_table_mem (
        .aclk     (aclk),
        .wr_en    (accept && is_load
                   && (CMPW'(s_table_index) < CMPW'(TABLE_BYTES))),
        .wr_addr  (AW'(s_table_index)),
        .wr_data  (s_table_byte),
        .rd_en    (accept && is_lookup),
        .rd_addr_a(AW'(pos0)),
        .rd_addr_b(AW'(pos1)),
        .rd_data_a(rd_a),
        .rd_data_b(rd_b)
    );

    // capture the lookup; the offset product rides along with the reads
    always_ff @(posedge aclk) begin
        if (accept && is_lookup) begin
            cl_reg       <= cl_sel;
            idle_adv_reg <= (s_cmd == CMD_ADVANCE) && !chain_active_reg;
            rng0_reg     <= CMPW'(pos0) < CMPW'(TABLE_BYTES);
            rng1_reg     <= CMPW'(pos1) < CMPW'(TABLE_BYTES);
            prod_reg     <= OFF_W'(cl_minus2) * OFF_W'(geo.cluster_bytes);
        end
    end

    // bytes past the end of the table read as zero
    assign pair  = {rng1_reg ? rd_b : 8'h00, rng0_reg ? rd_a : 8'h00};
    assign entry = cl_reg[0] ? pair[15:4] : pair[11:0];

    always_comb begin
        state_next        = state_reg;
        chain_active_next = chain_active_reg;
        pending_next      = pending_reg;
        res_write         = 1'b0;
        res_cl            = cl_reg;
        res_off           = '0;
        res_entry         = '0;
        res_status        = ST_NO_CHAIN;
        case (state_reg)
            T_IDLE: begin
                if (accept && is_lookup) begin
                    state_next = T_LOOK;
                end
            end
            T_LOOK: begin
                if (out_free) begin
                    res_write  = 1'b1;
                    state_next = T_IDLE;
                    if (idle_adv_reg) begin
                        // advance with no chain: all zero, state kept
                        res_cl     = '0;
                        res_status = ST_NO_CHAIN;
                    end else if (cl_reg == CL_W'(0)) begin
                        res_status        = ST_NO_CHAIN;
                        chain_active_next = 1'b0;
                    end else if (cl_reg == CL_W'(1)) begin
                        res_status        = ST_INVALID;
                        chain_active_next = 1'b0;
                    end else begin
                        res_off   = geo.base + prod_reg;
                        res_entry = entry;
                        if (entry >= ENTRY_LAST) begin
                            res_status        = ST_LAST;
                            chain_active_next = 1'b0;
                        end else if (entry == ENTRY_BAD) begin
                            res_status        = ST_BAD;
                            chain_active_next = 1'b0;
                        end else begin
                            res_status        = ST_CONTINUE;
                            pending_next      = entry;
                            chain_active_next = 1'b1;
                        end
                    end
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    assign m_valid_next = res_write || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= T_IDLE;
            chain_active_reg <= 1'b0;
            pending_reg      <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            chain_active_reg <= chain_active_next;
            pending_reg      <= pending_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_write) begin
            m_cl_reg     <= res_cl;
            m_off_reg    <= res_off;
            m_entry_reg  <= res_entry;
            m_status_reg <= res_status;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_cluster_number = m_cl_reg;
    assign m_data_offset    = m_off_reg;
    assign m_next_entry     = m_entry_reg;
    assign m_status         = m_status_reg;

    // a lookup transaction always enters the decode state next
    `ASSERT_NEXT(a_lookup_to_look, aclk, aresetn, accept && is_lookup, state_reg == T_LOOK)
    // nothing is taken while the data-area base is stale
    `ASSERT_ALWAYS(a_busy_blocks, aclk, aresetn, geo.busy |-> !s_ready)
    // a new result only appears out of the decode state
    `ASSERT_ALWAYS(a_result_src, aclk, aresetn, $rose(m_valid_reg) |-> $past(state_reg == T_LOOK))
    // a pending result is never overwritten
    `ASSERT_ALWAYS(a_no_overwrite, aclk, aresetn, (m_valid_reg && !m_ready) |-> !res_write)

endmodule

### rtl/fccw_table_mem.sv
module fccw_table_mem
    import fccw_pkg::*;
#(
    parameter int DEPTH = 8192,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr_a,
    input  logic [AW-1:0]     rd_addr_b,
    output logic [BYTE_W-1:0] rd_data_a,
    output logic [BYTE_W-1:0] rd_data_b
);

    logic [BYTE_W-1:0] table_mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_a_reg;
    logic [BYTE_W-1:0] rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a_reg <= table_mem[rd_addr_a];
            rd_data_b_reg <= table_mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

### rtl/fccw_geometry.sv
module fccw_geometry
    import fccw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CFGI_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    output geo_t              geo
);

    localparam int DIVD_W = 22;   // root_entries*32 + bytes_per_sector - 1
    localparam int CNT_W  = $clog2(DIVD_W);

    typedef enum logic [5:0] {
        G_IDLE = 6'b000001,
        G_LOAD = 6'b000010,
        G_DIV  = 6'b000100,
        G_MUL  = 6'b001000,
        G_SUM  = 6'b010000,
        G_BASE = 6'b100000
    } gstate_t;

    gstate_t state_reg, state_next;

    logic [12:0] bps_reg;
    logic [7:0]  spc_reg;
    logic [15:0] rsv_reg;
    logic [7:0]  copies_reg;
    logic [15:0] root_reg;
    logic [15:0] tsec_reg;

    logic [DIVD_W-1:0]  dividend_reg;
    logic [12:0]        rem_reg;
    logic [DIVD_W-1:0]  quot_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [23:0]        tprod_reg;
    logic [24:0]        sectors_reg;
    logic [CBYTE_W-1:0] cbytes_reg;
    logic [OFF_W-1:0]   base_reg;

    logic [13:0] rem_shift;
    logic        rem_ge;

    assign rem_shift = {rem_reg, dividend_reg[DIVD_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, bps_reg};

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bps_reg    <= 13'd512;
            spc_reg    <= 8'd1;
            rsv_reg    <= 16'd1;
            copies_reg <= 8'd2;
            root_reg   <= 16'd224;
            tsec_reg   <= 16'd9;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BYTES_PER_SECTOR:    bps_reg    <= cfg_wr_data[12:0];
                CFG_SECTORS_PER_CLUSTER: spc_reg    <= cfg_wr_data[7:0];
                CFG_RESERVED_SECTORS:    rsv_reg    <= cfg_wr_data;
                CFG_TABLE_COPIES:        copies_reg <= cfg_wr_data[7:0];
                CFG_ROOT_ENTRIES:        root_reg   <= cfg_wr_data;
                CFG_TABLE_SECTORS:       tsec_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            G_IDLE: state_next = G_IDLE;
            G_LOAD: state_next = G_DIV;
            G_DIV:  state_next = (cnt_reg == '0) ? G_MUL : G_DIV;
            G_MUL:  state_next = G_SUM;
            G_SUM:  state_next = G_BASE;
            G_BASE: state_next = G_IDLE;
            default: state_next = G_LOAD;
        endcase
        // any write restarts the recompute
        if (cfg_wr_en) begin
            state_next = G_LOAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= G_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // root sectors by restoring division, one quotient bit a cycle
    always_ff @(posedge aclk) begin
        case (state_reg)
            G_LOAD: begin
                dividend_reg <= DIVD_W'({root_reg, {DIR_ENTRY_SHIFT{1'b0}}})
                              + DIVD_W'(bps_reg) - DIVD_W'(1);
                rem_reg      <= '0;
                quot_reg     <= '0;
                cnt_reg      <= CNT_W'(DIVD_W - 1);
            end
            G_DIV: begin
                dividend_reg <= dividend_reg << 1;
                quot_reg     <= {quot_reg[DIVD_W-2:0], rem_ge};
                rem_reg      <= rem_ge ? 13'(rem_shift - {1'b0, bps_reg})
                                       : rem_shift[12:0];
                cnt_reg      <= cnt_reg - CNT_W'(1);
            end
            G_MUL: begin
                tprod_reg  <= 24'(copies_reg) * 24'(tsec_reg);
                cbytes_reg <= CBYTE_W'(spc_reg) * CBYTE_W'(bps_reg);
            end
            G_SUM: begin
                sectors_reg <= 25'(rsv_reg) + 25'(tprod_reg)
                             + ((bps_reg == '0) ? 25'd0 : 25'(quot_reg));
            end
            G_BASE: begin
                base_reg <= OFF_W'(sectors_reg) * OFF_W'(bps_reg);
            end
            default: ;
        endcase
    end

    assign geo.base          = base_reg;
    assign geo.cluster_bytes = cbytes_reg;
    assign geo.busy          = (state_reg != G_IDLE);

endmodule
